@@ hw/rtl/sbda_pkg.sv @@
// Package for the signed binary to decimal ASCII converter: widths, characters,
// sequencer step, opcode and condition codes, and the microcode table.
// No dependencies; every other file of the block depends on it.
`timescale 1ns / 1ps
`default_nettype none

package sbda_pkg;

   localparam int IN_WIDTH            = 64;
   localparam int DEFAULT_VALUE_WIDTH = 64;
   localparam int CHAR_WIDTH          = 6;
   localparam int BCD_BITS            = 4;
   localparam int DABBLE_BITS         = 4;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

   localparam int STEP_WIDTH = 3;
   localparam logic [STEP_WIDTH-1:0] STEP_IDLE    = 3'd0;
   localparam logic [STEP_WIDTH-1:0] STEP_CONVERT = 3'd1;
   localparam logic [STEP_WIDTH-1:0] STEP_TRIM    = 3'd2;
   localparam logic [STEP_WIDTH-1:0] STEP_SIGN    = 3'd3;
   localparam logic [STEP_WIDTH-1:0] STEP_DIGIT   = 3'd4;

   localparam logic [2:0] OP_NONE    = 3'd0;
   localparam logic [2:0] OP_LOAD    = 3'd1;
   localparam logic [2:0] OP_CONVERT = 3'd2;
   localparam logic [2:0] OP_TRIM    = 3'd3;
   localparam logic [2:0] OP_SIGN    = 3'd4;
   localparam logic [2:0] OP_DIGIT   = 3'd5;

   localparam logic [2:0] COND_ALWAYS    = 3'd0;
   localparam logic [2:0] COND_REQ       = 3'd1;
   localparam logic [2:0] COND_CONV_DONE = 3'd2;
   localparam logic [2:0] COND_LEAD_DONE = 3'd3;
   localparam logic [2:0] COND_SIGN_DONE = 3'd4;
   localparam logic [2:0] COND_LAST_OUT  = 3'd5;

   typedef struct packed {
      logic [2:0]            op;
      logic [2:0]            cond;
      logic [STEP_WIDTH-1:0] target;
   } ucode_word_type;

   typedef struct packed {
      logic load;
      logic convert;
      logic shift;
   } dp_ctrl_type;

   // Decimal digits needed for a magnitude of up to 2^width - 1.
   function automatic int digit_count(input int width);
      return (width * 30103) / 100000 + 1;
   endfunction

   // The sequencer stays on a step until its condition holds, then jumps.
   function automatic ucode_word_type ucode_rom(input logic [STEP_WIDTH-1:0] step);
      ucode_word_type word;
      case (step)
         STEP_IDLE:    word = '{op: OP_LOAD,    cond: COND_REQ,       target: STEP_CONVERT};
         STEP_CONVERT: word = '{op: OP_CONVERT, cond: COND_CONV_DONE, target: STEP_TRIM};
         STEP_TRIM:    word = '{op: OP_TRIM,    cond: COND_LEAD_DONE, target: STEP_SIGN};
         STEP_SIGN:    word = '{op: OP_SIGN,    cond: COND_SIGN_DONE, target: STEP_DIGIT};
         STEP_DIGIT:   word = '{op: OP_DIGIT,   cond: COND_LAST_OUT,  target: STEP_IDLE};
         default:      word = '{op: OP_NONE,    cond: COND_ALWAYS,    target: STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sbda_if.sv @@
// Valid/ready channel interfaces for the request and response streams.
// Depends on sbda_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface sbda_req_if;
   logic                          valid;
   logic                          ready;
   logic [sbda_pkg::IN_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface sbda_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sbda_pkg::CHAR_WIDTH-1:0] character;
   logic                            last;

   modport source (output valid, output character, output last, input ready);
   modport sink (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sbda_bcd_dp.sv @@
// Conversion datapath: magnitude and BCD shift registers with a double-dabble
// step of several bits per cycle. Depends on sbda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbda_bcd_dp #(
   parameter int VALUE_WIDTH = sbda_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                          clock,
   input  sbda_pkg::dp_ctrl_type         ctrl,
   input  logic [VALUE_WIDTH-1:0]        value_in,
   output logic [sbda_pkg::BCD_BITS-1:0] top_digit
);
   import sbda_pkg::*;

   localparam int ConvSteps  = (VALUE_WIDTH + DABBLE_BITS - 1) / DABBLE_BITS;
   localparam int PadWidth   = ConvSteps * DABBLE_BITS;
   localparam int DigitCount = digit_count(VALUE_WIDTH);
   localparam int BcdWidth   = DigitCount * BCD_BITS;

   logic [PadWidth-1:0]    mag_ff;
   logic [PadWidth-1:0]    mag_in;
   logic [BcdWidth-1:0]    bcd_ff;
   logic [BcdWidth-1:0]    bcd_in;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic [PadWidth-1:0]    mag_work;
   logic [BcdWidth-1:0]    bcd_work;

   assign magnitude = value_in[VALUE_WIDTH-1] ? (~value_in + 1'b1) : value_in;

   always_comb begin
      bcd_work = bcd_ff;
      mag_work = mag_ff;
      for (int b = 0; b < DABBLE_BITS; b++) begin
         for (int d = 0; d < DigitCount; d++) begin
            if (bcd_work[d*BCD_BITS +: BCD_BITS] >= 4'd5) begin
               bcd_work[d*BCD_BITS +: BCD_BITS] = bcd_work[d*BCD_BITS +: BCD_BITS] + 4'd3;
            end
         end
         bcd_work = {bcd_work[BcdWidth-2:0], mag_work[PadWidth-1]};
         mag_work = {mag_work[PadWidth-2:0], 1'b0};
      end
   end

   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         mag_in = PadWidth'(magnitude);
         bcd_in = '0;
      end else if (ctrl.convert) begin
         mag_in = mag_work;
         bcd_in = bcd_work;
      end else if (ctrl.shift) begin
         bcd_in = {bcd_ff[BcdWidth-BCD_BITS-1:0], {BCD_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BcdWidth-1 -: BCD_BITS];

endmodule

`default_nettype wire

@@ hw/rtl/signed_binary_to_decimal_ascii.sv @@
// Top level of the signed binary to decimal ASCII converter: microcoded
// sequencer, output register and assertions. Depends on sbda_pkg, sbda_if
// and sbda_bcd_dp.
//
//  Channel  Direction  Payload                 Transfer
//  req_ch   in         value[63:0] signed      valid & ready
//  rsp_ch   out        character[5:0], last    valid & ready
//
// A request is taken only in the idle step; the magnitude then goes through
// the double-dabble conversion steps, a trim step that drops each leading zero
// digit, a sign step and a digit step that sends the digits one by one.
// A stalled response holds the sequencer in the sign or digit step.
// Reset is synchronous and clears the sequencer and the response valid.
`timescale 1ns / 1ps
`default_nettype none

module signed_binary_to_decimal_ascii #(
   parameter int VALUE_WIDTH = sbda_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   sbda_req_if.sink   req_ch,
   sbda_rsp_if.source rsp_ch
);
   import sbda_pkg::*;

   localparam int ConvSteps  = (VALUE_WIDTH + DABBLE_BITS - 1) / DABBLE_BITS;
   localparam int CntWidth   = (ConvSteps > 1) ? $clog2(ConvSteps) : 1;
   localparam int DigitCount = digit_count(VALUE_WIDTH);
   localparam int LeftWidth  = $clog2(DigitCount + 1);

   logic [STEP_WIDTH-1:0] step_ff;
   logic [STEP_WIDTH-1:0] step_in;
   logic [CntWidth-1:0]   cnt_ff;
   logic [CntWidth-1:0]   cnt_in;
   logic [LeftWidth-1:0]  left_ff;
   logic [LeftWidth-1:0]  left_in;
   logic                  neg_ff;
   logic                  neg_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [CHAR_WIDTH-1:0] rsp_char_ff;
   logic [CHAR_WIDTH-1:0] rsp_char_in;
   logic                  rsp_last_ff;
   logic                  rsp_last_in;

   ucode_word_type        uword;
   dp_ctrl_type           dp_ctrl;
   logic [BCD_BITS-1:0]   top_digit;
   logic                  slot_free;
   logic                  cond_true;
   logic                  emit;

   sbda_bcd_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_bcd_dp (
      .clock     (clock),
      .ctrl      (dp_ctrl),
      .value_in  (req_ch.value[VALUE_WIDTH-1:0]),
      .top_digit (top_digit)
   );

   assign uword     = ucode_rom(step_ff);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      case (uword.cond)
         COND_ALWAYS:    cond_true = 1'b1;
         COND_REQ:       cond_true = req_ch.valid;
         COND_CONV_DONE: cond_true = (cnt_ff == CntWidth'(ConvSteps - 1));
         COND_LEAD_DONE: cond_true = (top_digit != '0) || (left_ff == LeftWidth'(1));
         COND_SIGN_DONE: cond_true = !neg_ff || slot_free;
         COND_LAST_OUT:  cond_true = slot_free && (left_ff == LeftWidth'(1));
         default:        cond_true = 1'b0;
      endcase
   end

   always_comb begin
      step_in     = cond_true ? uword.target : step_ff;
      cnt_in      = cnt_ff;
      left_in     = left_ff;
      neg_in      = neg_ff;
      dp_ctrl     = '0;
      emit        = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      case (uword.op)
         OP_LOAD: begin
            if (req_ch.valid) begin
               dp_ctrl.load = 1'b1;
               cnt_in       = '0;
               left_in      = LeftWidth'(DigitCount);
               neg_in       = req_ch.value[VALUE_WIDTH-1];
            end
         end
         OP_CONVERT: begin
            dp_ctrl.convert = 1'b1;
            cnt_in          = cnt_ff + 1'b1;
         end
         OP_TRIM: begin
            if (!cond_true) begin
               dp_ctrl.shift = 1'b1;
               left_in       = left_ff - 1'b1;
            end
         end
         OP_SIGN: begin
            if (neg_ff && slot_free) begin
               emit        = 1'b1;
               rsp_char_in = CHAR_MINUS;
               rsp_last_in = 1'b0;
            end
         end
         OP_DIGIT: begin
            if (slot_free) begin
               emit          = 1'b1;
               rsp_char_in   = CHAR_ZERO | CHAR_WIDTH'(top_digit);
               rsp_last_in   = (left_ff == LeftWidth'(1));
               dp_ctrl.shift = 1'b1;
               left_in       = left_ff - 1'b1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      rsp_valid_in = emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         cnt_ff       <= '0;
         left_ff      <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         left_ff      <= left_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ch.ready     = (uword.op == OP_LOAD);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.character = rsp_char_ff;
   assign rsp_ch.last      = rsp_last_ff;

   // A taken request always starts the conversion loop on the next cycle.
   a_load_to_convert: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> step_ff == STEP_CONVERT)
      else $error("conversion did not start after a request");

   // The count of digits left never grows past the digit count of the BCD register.
   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      left_ff <= LeftWidth'(DigitCount))
      else $error("digit count out of range");

   // The digit step always has at least one digit left to send.
   a_digit_left: assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_DIGIT |-> left_ff != '0)
      else $error("digit step with no digits left");

   // Every digit that leaves is a decimal digit.
   a_decimal_digit: assert property (@(posedge clock) disable iff (reset)
      emit && uword.op == OP_DIGIT |-> top_digit <= 4'd9)
      else $error("non-decimal BCD digit");

endmodule

`default_nettype wire
